/* rtl/tics_pkg.sv */
// Shared types, constants and codes for the table interpolation core.
`default_nettype none
package tics_pkg;
  localparam int TableDepthDef = 256;
  localparam logic [30:0] MeshHeightRst = 31'd512000;
  localparam logic [8:0] PointCountRst = 9'd2;
  localparam logic signed [31:0] NoSegValue = -32'sd6144;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic {
    CFG_MESH_HEIGHT = 1'b0,
    CFG_POINT_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_LAST,
    ST_RD_FIRST,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_RD_SEG,
    ST_DIV_BED,
    ST_DIV_SURF,
    ST_MUL,
    ST_DIV_BLEND,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic rd_last;
    logic rd_first;
    logic rd_scan;
    logic scan_step;
    logic rd_seg;
    logic div_start;
    logic [1:0] div_sel;
    logic do_mul;
    logic finish;
    logic set_clamp;
    logic set_noseg;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic above_last;
    logic below_first;
    logic one_point;
    logic bracket;
    logic scan_end;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/tics_div.sv */
// Restoring serial divider, one quotient bit per cycle, unsigned.
`default_nettype none
module tics_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, rem_r, rem_nxt, dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[W-1]} - {1'b0, dvs_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

/* rtl/tics_dp.sv */
// Datapath: point tables, scan registers, interpolation and blend arithmetic.
`default_nettype none
module tics_dp #(
  parameter int TABLE_DEPTH = tics_pkg::TableDepthDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tics_pkg::ctl_t       ctl,
  output tics_pkg::sts_t            sts,
  input  wire logic [7:0]           in_point_index,
  input  wire logic signed [31:0]   in_position,
  input  wire logic signed [31:0]   in_bed_value,
  input  wire logic signed [31:0]   in_surface_value,
  input  wire logic signed [31:0]   in_column_height,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_index,
  input  wire logic [30:0]          cfg_wr_data,
  output logic signed [31:0]        out_new_height,
  output logic signed [31:0]        out_bed_at_pos,
  output logic signed [31:0]        out_surface_at_pos,
  output logic                      out_no_segment,
  output logic                      out_saturated
);
  import tics_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic [95:0] mem [TABLE_DEPTH];
  logic [95:0] rd_r;
  logic [95:0] left_r;
  logic [AW-1:0] rd_addr, idx_r;
  logic [30:0] mesh_r;
  logic [8:0] pcnt_r;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] last_idx;
  logic signed [31:0] xq_r, h_r, pos_lo, pos_hi;
  logic signed [32:0] bed_r, surf_r;
  logic [32:0] mag_r;
  logic [63:0] prod_r;
  logic signed [34:0] dy_b, dy_s;
  logic signed [34:0] sdb, sds;
  logic [32:0] num_r, den_r;
  logic neg_b_r, neg_s_r, neg_m_r;
  logic [63:0] segtab_r, mulp_r;
  logic [63:0] div_a, div_b, div_q;
  logic div_done, div_go_r;
  logic [40:0] q_clip_r;
  logic signed [42:0] res;
  logic sat, sat_r;
  logic signed [31:0] nh_r, ob_r, os_r;
  logic nos_r;

  always_comb begin
    if (pcnt_r == 9'd0) n_eff = NW'(1);
    else if (int'(pcnt_r) > TABLE_DEPTH) n_eff = NW'(TABLE_DEPTH);
    else n_eff = NW'(pcnt_r);
  end
  assign last_idx = AW'(n_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_r <= MeshHeightRst;
      pcnt_r <= PointCountRst;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MESH_HEIGHT) mesh_r <= cfg_wr_data;
      else pcnt_r <= cfg_wr_data[8:0];
    end
  end

  always_comb begin
    rd_addr = idx_r;
    if (ctl.rd_last) rd_addr = last_idx;
    else if (ctl.rd_first) rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr && (int'(in_point_index) < TABLE_DEPTH))
      mem[AW'(in_point_index)] <= {in_position, in_bed_value, in_surface_value};
    rd_r <= mem[rd_addr];
  end

  assign pos_hi = rd_r[95:64];
  assign pos_lo = left_r[95:64];

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      xq_r <= in_position;
      h_r <= in_column_height;
      idx_r <= '0;
      nos_r <= 1'b0;
    end
    if (ctl.rd_scan) left_r <= rd_r;
    if (ctl.scan_step) idx_r <= idx_r + 1'b1;
    if (ctl.set_clamp) begin
      bed_r <= 33'(signed'(rd_r[63:32]));
      surf_r <= 33'(signed'(rd_r[31:0]));
    end
    if (ctl.set_noseg) begin
      bed_r <= 33'(NoSegValue);
      surf_r <= 33'(NoSegValue);
      nos_r <= 1'b1;
    end
    if (ctl.rd_seg) begin
      num_r <= 33'({xq_r[31], xq_r} - {pos_lo[31], pos_lo});
      den_r <= 33'({pos_hi[31], pos_hi} - {pos_lo[31], pos_lo});
      neg_b_r <= dy_b < 0;
      neg_s_r <= dy_s < 0;
    end
    if (div_done && ctl.div_sel == 2'd0) begin
      bed_r <= neg_b_r ? 33'(signed'(left_r[63:32])) - 33'(div_q)
                       : 33'(signed'(left_r[63:32])) + 33'(div_q);
    end
    if (div_done && ctl.div_sel == 2'd1) begin
      surf_r <= neg_s_r ? 33'(signed'(left_r[31:0])) - 33'(div_q)
                        : 33'(signed'(left_r[31:0])) + 33'(div_q);
    end
    if (ctl.do_mul) begin
      prod_r <= 64'(mag_r) * 64'(h_r[31] ? 33'(-{h_r[31], h_r}) : 33'(h_r));
      neg_m_r <= ((surf_r - bed_r) < 0) != h_r[31] && (surf_r != bed_r) && (h_r != 0);
    end
    if (ctl.finish) begin
      nh_r <= sat ? (res[42] ? 32'sh80000000 : 32'sh7fffffff) : res[31:0];
      ob_r <= bed_r[31:0];
      os_r <= surf_r[31:0];
    end
    if (ctl.out_load) begin
      nh_r <= '0; ob_r <= '0; os_r <= '0;
    end
  end

  // magnitude of surface - bed for blend
  always_ff @(posedge clk) begin
    if (ctl.div_sel == 2'd2 && ctl.div_start == 1'b0 && !ctl.do_mul) begin
      mag_r <= (surf_r - bed_r) < 0 ? 33'(bed_r - surf_r) : 33'(surf_r - bed_r);
    end
  end

  assign dy_b = 35'(signed'(rd_r[63:32])) - 35'(signed'(left_r[63:32]));
  assign dy_s = 35'(signed'(rd_r[31:0])) - 35'(signed'(left_r[31:0]));

  // interpolation: |dy|*num/den ; dy magnitude recomputed from stored ends
  always_ff @(posedge clk) begin
    if (ctl.rd_seg) segtab_r <= 64'(rd_r[63:0]);
  end
  assign sdb = 35'(signed'(segtab_r[63:32])) - 35'(signed'(left_r[63:32]));
  assign sds = 35'(signed'(segtab_r[31:0])) - 35'(signed'(left_r[31:0]));

  always_ff @(posedge clk) begin
    if (ctl.div_start && ctl.div_sel == 2'd0)
      mulp_r <= 64'(sdb < 0 ? 33'(-sdb) : 33'(sdb)) * 64'(num_r);
    else if (ctl.div_start && ctl.div_sel == 2'd1)
      mulp_r <= 64'(sds < 0 ? 33'(-sds) : 33'(sds)) * 64'(num_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else div_go_r <= ctl.div_start;
  end

  always_comb begin
    if (ctl.div_sel == 2'd2) begin
      div_a = prod_r;
      div_b = 64'(mesh_r == 31'd0 ? 31'd1 : mesh_r);
    end else begin
      div_a = mulp_r;
      div_b = 64'(den_r);
    end
  end

  tics_div #(.W(64)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend(div_a), .divisor(div_b), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done && ctl.div_sel == 2'd2) begin
      q_clip_r <= div_q > 64'h100_0000_0000 ? 41'h100_0000_0000 : 41'(div_q);
    end
  end

  assign res = neg_m_r ? 43'(bed_r) - 43'(q_clip_r) : 43'(bed_r) + 43'(q_clip_r);
  always_comb sat = (res > 43'sh7fffffff) || (res < -43'sh80000000);
  always_ff @(posedge clk) begin
    if (ctl.finish) sat_r <= sat;
    if (ctl.out_load) sat_r <= 1'b0;
  end

  assign sts.div_done = div_done;
  assign sts.above_last = xq_r >= pos_hi;
  assign sts.below_first = xq_r <= pos_hi;
  assign sts.one_point = n_eff == NW'(1);
  assign sts.bracket = (xq_r >= pos_lo) && (xq_r <= pos_hi);
  assign sts.scan_end = NW'(idx_r) + 1'b1 >= n_eff;

  assign out_new_height = nh_r;
  assign out_bed_at_pos = ob_r;
  assign out_surface_at_pos = os_r;
  assign out_no_segment = nos_r;
  assign out_saturated = sat_r;
endmodule
`default_nettype wire

/* rtl/tics_ctrl.sv */
// Controller: sequences load, table scan, divisions and result handshake.
`default_nettype none
module tics_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_req_type,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tics_pkg::sts_t sts,
  output tics_pkg::ctl_t      ctl
);
  import tics_pkg::*;
  state_t st_r, st_nxt;
  logic wait_r, wait_nxt;

  always_comb begin
    st_nxt = st_r;
    wait_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE:
        if (in_valid) st_nxt = (in_req_type == REQ_QUERY) ? ST_RD_LAST : ST_LOAD;
      ST_LOAD: st_nxt = ST_OUT;
      ST_RD_LAST: begin
        wait_nxt = !wait_r;
        if (wait_r) st_nxt = (sts.above_last || sts.one_point) ? ST_MUL : ST_RD_FIRST;
      end
      ST_RD_FIRST: begin
        wait_nxt = !wait_r;
        if (wait_r) st_nxt = sts.below_first ? ST_MUL : ST_SCAN;
      end
      ST_SCAN: begin
        wait_nxt = !wait_r;
        if (wait_r) st_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        wait_nxt = !wait_r;
        if (wait_r) begin
          if (sts.bracket) st_nxt = ST_RD_SEG;
          else if (sts.scan_end) st_nxt = ST_MUL;
          else st_nxt = ST_SCAN;
        end
      end
      ST_RD_SEG: st_nxt = ST_DIV_BED;
      ST_DIV_BED: begin
        wait_nxt = 1'b1;
        if (wait_r && sts.div_done) begin
          st_nxt = ST_DIV_SURF;
          wait_nxt = 1'b0;
        end
      end
      ST_DIV_SURF: begin
        wait_nxt = 1'b1;
        if (wait_r && sts.div_done) begin
          st_nxt = ST_MUL;
          wait_nxt = 1'b0;
        end
      end
      ST_MUL: begin
        wait_nxt = !wait_r;
        if (wait_r) st_nxt = ST_DIV_BLEND;
      end
      ST_DIV_BLEND: begin
        wait_nxt = 1'b1;
        if (wait_r && sts.div_done) begin
          st_nxt = ST_FINISH;
          wait_nxt = 1'b0;
        end
      end
      ST_FINISH: st_nxt = ST_OUT;
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.div_sel = 2'd2;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.capture = in_valid;
        ctl.load_wr = in_valid && (in_req_type == REQ_LOAD);
      end
      ST_LOAD: ctl.out_load = 1'b1;
      ST_RD_LAST: begin
        ctl.rd_last = !wait_r;
        ctl.div_sel = 2'd3;
        ctl.set_clamp = wait_r && (sts.above_last || sts.one_point);
      end
      ST_RD_FIRST: begin
        ctl.rd_first = !wait_r;
        ctl.div_sel = 2'd3;
        ctl.set_clamp = wait_r && sts.below_first;
      end
      ST_SCAN: begin
        ctl.div_sel = 2'd3;
        ctl.rd_scan = wait_r;
        ctl.scan_step = wait_r;
      end
      ST_SCAN_CHK: begin
        ctl.div_sel = 2'd3;
        ctl.set_noseg = wait_r && !sts.bracket && sts.scan_end;
      end
      ST_RD_SEG: begin
        ctl.rd_seg = 1'b1;
        ctl.div_sel = 2'd3;
      end
      ST_DIV_BED: begin
        ctl.div_sel = 2'd0;
        ctl.div_start = !wait_r;
      end
      ST_DIV_SURF: begin
        ctl.div_sel = 2'd1;
        ctl.div_start = !wait_r;
      end
      ST_MUL: begin
        ctl.do_mul = wait_r;
        ctl.div_sel = wait_r ? 2'd3 : 2'd2;
      end
      ST_DIV_BLEND: begin
        ctl.div_sel = 2'd2;
        ctl.div_start = !wait_r;
        ctl.do_mul = 1'b0;
      end
      ST_FINISH: begin
        ctl.div_sel = 2'd3;
        ctl.finish = 1'b1;
      end
      ST_OUT: begin
        ctl.div_sel = 2'd3;
        out_valid = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wait_r <= wait_nxt;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule
`default_nettype wire

/* rtl/table_interp_column_stretch_core.sv */
// Sequence: a load writes one point and returns a zeroed result beat; a query is clamped
// at the last or first point, or scans the segments in order and then reports no segment or
// interpolates. Each divide is a 64-bit serial divide; a query runs one or three.
// Throughput: one item at a time; the next beat is accepted in the cycle after the result beat.
// Reset (synchronous, active low) clears control and sets mesh_height and point_count;
// the point table is not cleared and holds unknown data until loaded.
`default_nettype none
module table_interp_column_stretch_core #(
  parameter int TABLE_DEPTH = tics_pkg::TableDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic [7:0]         in_point_index,
  input  wire logic signed [31:0] in_position,
  input  wire logic signed [31:0] in_bed_value,
  input  wire logic signed [31:0] in_surface_value,
  input  wire logic signed [31:0] in_column_height,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_new_height,
  output logic signed [31:0]      out_bed_at_pos,
  output logic signed [31:0]      out_surface_at_pos,
  output logic                    out_no_segment,
  output logic                    out_saturated,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_wr_data
);
  import tics_pkg::*;
  ctl_t ctl;
  sts_t sts;

  tics_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .ctl(ctl)
  );

  tics_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_point_index(in_point_index), .in_position(in_position),
    .in_bed_value(in_bed_value), .in_surface_value(in_surface_value),
    .in_column_height(in_column_height),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .out_new_height(out_new_height), .out_bed_at_pos(out_bed_at_pos),
    .out_surface_at_pos(out_surface_at_pos), .out_no_segment(out_no_segment),
    .out_saturated(out_saturated)
  );
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the table interpolation and column stretch core.
`timescale 1ns / 1ps
module tb_top;
  import tics_pkg::*;

  localparam int Depth = 256;
  localparam int IntMax = 32'sh7fffffff;
  localparam int IntMin = 32'sh80000000;

  typedef struct {
    int   new_height;
    int   bed;
    int   surf;
    logic no_seg;
    logic sat;
  } stretch_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [7:0] in_point_index = '0;
  logic signed [31:0] in_position = '0;
  logic signed [31:0] in_bed_value = '0;
  logic signed [31:0] in_surface_value = '0;
  logic signed [31:0] in_column_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_new_height;
  logic signed [31:0] out_bed_at_pos;
  logic signed [31:0] out_surface_at_pos;
  logic out_no_segment;
  logic out_saturated;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_wr_data = '0;

  table_interp_column_stretch_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_point_index(in_point_index),
    .in_position(in_position), .in_bed_value(in_bed_value),
    .in_surface_value(in_surface_value), .in_column_height(in_column_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_height(out_new_height), .out_bed_at_pos(out_bed_at_pos),
    .out_surface_at_pos(out_surface_at_pos), .out_no_segment(out_no_segment),
    .out_saturated(out_saturated),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block state
  logic [30:0] mesh_mirror;
  logic [8:0] count_mirror;
  int pos_tbl[Depth];
  int bed_tbl[Depth];
  int surf_tbl[Depth];

  stretch_res_t height_q[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint seg_blend(longint y0, longint y1, longint num, longint den);
    longint dy;
    logic [63:0] mag, hi, lo, t, uden, unum;
    if (den == 0) return y0;
    uden = den;
    unum = num;
    dy = y1 - y0;
    mag = (dy < 0) ? -dy : dy;
    hi = mag / uden;
    lo = mag % uden;
    t = hi * unum + (lo * unum) / uden;
    return (dy < 0) ? y0 - longint'(t) : y0 + longint'(t);
  endfunction

  function automatic stretch_res_t stretch_height(int xq_i, int h_i);
    stretch_res_t r;
    longint xq, h, bed, surf, ds, res;
    logic [63:0] dmag, hmag, q, den;
    logic neg;
    int n;
    xq = xq_i;
    h = h_i;
    n = count_mirror;
    if (n < 1) n = 1;
    if (n > Depth) n = Depth;
    r.no_seg = 1'b1;
    r.sat = 1'b0;
    bed = NoSegValue;
    surf = NoSegValue;
    if (xq >= pos_tbl[n-1]) begin
      bed = bed_tbl[n-1]; surf = surf_tbl[n-1]; r.no_seg = 1'b0;
    end else if (xq <= pos_tbl[0]) begin
      bed = bed_tbl[0]; surf = surf_tbl[0]; r.no_seg = 1'b0;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (r.no_seg && xq >= pos_tbl[i] && xq <= pos_tbl[i+1]) begin
          bed = seg_blend(bed_tbl[i], bed_tbl[i+1], xq - pos_tbl[i],
                          longint'(pos_tbl[i+1]) - pos_tbl[i]);
          surf = seg_blend(surf_tbl[i], surf_tbl[i+1], xq - pos_tbl[i],
                           longint'(pos_tbl[i+1]) - pos_tbl[i]);
          r.no_seg = 1'b0;
        end
      end
    end
    ds = surf - bed;
    dmag = (ds < 0) ? -ds : ds;
    hmag = (h < 0) ? -h : h;
    neg = ((ds < 0) != (h < 0)) && dmag != 0 && hmag != 0;
    den = (mesh_mirror != 0) ? mesh_mirror : 1;
    q = (dmag * hmag) / den;
    if (q > 64'd1 << 40) q = 64'd1 << 40;
    res = neg ? bed - longint'(q) : bed + longint'(q);
    if (res > IntMax) begin res = IntMax; r.sat = 1'b1; end
    if (res < IntMin) begin res = IntMin; r.sat = 1'b1; end
    r.new_height = int'(res);
    r.bed = int'(bed);
    r.surf = int'(surf);
    return r;
  endfunction

  task automatic send_beat(req_t rt, logic [7:0] idx, int pos, int bed, int surf, int h);
    stretch_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_point_index <= idx;
    in_position <= pos;
    in_bed_value <= bed;
    in_surface_value <= surf;
    in_column_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rt == REQ_LOAD) begin
      pos_tbl[idx] = pos; bed_tbl[idx] = bed; surf_tbl[idx] = surf;
      r = '{0, 0, 0, 1'b0, 1'b0};
    end else begin
      r = stretch_height(pos, h);
    end
    height_q.push_back(r);
  endtask

  task automatic load_point(int idx, int pos, int bed, int surf);
    send_beat(REQ_LOAD, idx[7:0], pos, bed, surf, $urandom);
  endtask

  task automatic query(int pos, int h);
    send_beat(REQ_QUERY, 8'($urandom), pos, $urandom, $urandom, h);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (height_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [30:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MESH_HEIGHT) mesh_mirror = val;
    else count_mirror = val[8:0];
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    stretch_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (height_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = height_q.pop_front();
        if (out_new_height !== e.new_height)
          report_mismatch("new_height", out_new_height, e.new_height);
        if (out_bed_at_pos !== e.bed) report_mismatch("bed_at_pos", out_bed_at_pos, e.bed);
        if (out_surface_at_pos !== e.surf)
          report_mismatch("surface_at_pos", out_surface_at_pos, e.surf);
        if (out_no_segment !== e.no_seg)
          report_mismatch("no_segment", out_no_segment, e.no_seg);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
      end
    end
  end

  // sorted table of n points from index 0; occasional duplicates, and disorder when unsorted is set
  task automatic load_table(int n, bit unsorted);
    longint p;
    int step_scale;
    p = longint'($signed($urandom)) / longint'($urandom_range(1, 4) * 2);
    step_scale = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      load_point(i, int'(p), $urandom, $urandom);
      case (step_scale)
        0: p += $urandom_range(0, 2000);
        1: p += $urandom_range(0, 1 << 20);
        default: p += $urandom_range(0, 32'h3fffffff);
      endcase
      if (unsorted && $urandom_range(3) == 0) p -= $urandom_range(0, 1 << 21);
      if ($urandom_range(9) == 0) p -= 0;
      if (p > IntMax) p = IntMax;
      if (p < IntMin) p = IntMin;
    end
  endtask

  task automatic random_query(int n);
    int pos, h, k;
    longint lo, hi;
    n = (n < 1) ? 1 : (n > Depth) ? Depth : n;
    lo = pos_tbl[0];
    hi = pos_tbl[n-1];
    case ($urandom_range(9))
      0: pos = $urandom;
      1: pos = pos_tbl[$urandom_range(0, n - 1)];
      2: pos = (lo > IntMin) ? int'(lo - 1) : int'(lo);
      default: begin
        if (hi > lo) pos = int'(lo + (longint'($urandom) % (hi - lo + 1)));
        else pos = int'(lo);
      end
    endcase
    k = $urandom_range(9);
    if (k < 6) h = $urandom_range(0, mesh_mirror);
    else if (k < 8) h = -$signed($urandom_range(0, mesh_mirror));
    else h = $urandom;
    query(pos, h);
  endtask

  task automatic test_fill_table();
    load_table(Depth, 1'b0);
    for (int i = 0; i < 8; i++) random_query(count_mirror);
  endtask

  task automatic test_directed();
    write_cfg(CFG_POINT_COUNT, 31'd4);
    load_point(0, -1000, IntMin, IntMax);
    load_point(1, 0, 0, -1);
    load_point(2, 0, 100, 200);
    load_point(3, IntMax, IntMax, IntMin);
    query(IntMin, 512000);
    query(IntMax, 0);
    query(-1000, IntMax);
    query(-500, IntMin);
    query(0, 256000);
    query(1 << 30, -256000);
    write_cfg(CFG_MESH_HEIGHT, 31'd1);
    query(-999, IntMax);
    query(IntMax - 1, IntMin);
    write_cfg(CFG_MESH_HEIGHT, 31'h7fffffff);
    query(-10, IntMax);
    write_cfg(CFG_MESH_HEIGHT, 31'd0);
    query(-700, 3);
    write_cfg(CFG_POINT_COUNT, 31'd0);
    query(5, 100);
    write_cfg(CFG_POINT_COUNT, 31'd1);
    query(-5000, 1024);
    write_cfg(CFG_POINT_COUNT, 31'd511);
    query($urandom, 77);
    write_cfg(CFG_POINT_COUNT, 31'd256);
    query($urandom, -77);
    write_cfg(CFG_MESH_HEIGHT, 31'd512000);
  endtask

  task automatic test_random_phases();
    int n, nq;
    bit fresh;
    logic [30:0] mesh;
    for (int ph = 0; ph < 44; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case ($urandom_range(7))
        0: mesh = 31'd1;
        1: mesh = 31'h7fffffff;
        2: mesh = 31'($urandom_range(1, 4096));
        default: mesh = 31'($urandom_range(1024, 1 << 22));
      endcase
      if (ph == 10 || ph == 30) n = Depth;
      else if ($urandom_range(9) == 0) n = $urandom_range(257, 511);
      else n = $urandom_range(0, 12);
      write_cfg(CFG_MESH_HEIGHT, mesh);
      write_cfg(CFG_POINT_COUNT, 31'(n));
      fresh = (ph != 30) && (n <= Depth);
      if (n > Depth) n = Depth;
      if (n < 1) n = 1;
      if (fresh) load_table(n, $urandom_range(5) == 0);
      nq = (n == Depth) ? 16 : 20;
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(19) == 0)
          load_point($urandom_range(0, n - 1), pos_tbl[$urandom_range(0, n - 1)],
                     $urandom, $urandom);
        random_query(count_mirror);
        if (j == 12 && ph % 5 == 0) drain();
      end
    end
  endtask

  initial begin
    mesh_mirror = MeshHeightRst;
    count_mirror = PointCountRst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_random_phases();
    drain();
    repeat (800) @(posedge clk);
    if (fail_count == 0 && height_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
